/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the connection table.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication under an active-low reset.
`define ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication under an active-low reset.
`define ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

/* rtl/ctt_pkg.sv */
// Package of the connection table: sizes, codes and shared structs.
// No dependencies.
`default_nettype none
package ctt_pkg;
  localparam int NUM_SLOTS    = 32;
  localparam int BUFFER_BYTES = 4096;
  localparam int SLOT_W       = $clog2(NUM_SLOTS);
  localparam int FILL_W       = 13;
  localparam int HANDLE_W     = 16;
  localparam int TIME_W       = 32;

  localparam logic [1:0] FN_DATA    = 2'd0;
  localparam logic [1:0] FN_PARSER  = 2'd1;
  localparam logic [1:0] FN_RELEASE = 2'd2;
  localparam logic [1:0] FN_SWEEP   = 2'd3;

  localparam logic [1:0] RK_BYTES  = 2'd0;
  localparam logic [1:0] RK_CLOSED = 2'd2;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADERS = 2'd1;
  localparam logic [1:0] PH_BODY    = 2'd2;

  localparam logic [3:0] ST_DELIVERED = 4'd0;
  localparam logic [3:0] ST_NODATA    = 4'd1;
  localparam logic [3:0] ST_FULL      = 4'd2;
  localparam logic [3:0] ST_HDR_OVF   = 4'd3;
  localparam logic [3:0] ST_BODY_OVF  = 4'd4;
  localparam logic [3:0] ST_CLOSED    = 4'd5;
  localparam logic [3:0] ST_TIMEOUT   = 4'd6;
  localparam logic [3:0] ST_RELEASED  = 4'd7;
  localparam logic [3:0] ST_PHASE     = 4'd8;
  localparam logic [3:0] ST_SWEEP     = 4'd9;

  localparam logic [1:0] REG_HEADER    = 2'd0;
  localparam logic [1:0] REG_BODY      = 2'd1;
  localparam logic [1:0] REG_KEEPALIVE = 2'd2;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [1:0]          phase;
    logic [FILL_W-1:0]   fill;
    logic [TIME_W-1:0]   last_seen;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [TIME_W-1:0] header_to;
    logic [TIME_W-1:0] body_to;
    logic [TIME_W-1:0] keepalive_to;
  } cfg_t;

  typedef struct packed {
    logic [3:0]          status;
    logic [4:0]          slot;
    logic [HANDLE_W-1:0] handle;
    logic [FILL_W-1:0]   fill;
    logic                last;
  } res_t;
endpackage
`default_nettype wire

/* rtl/connection_table_with_timeouts.sv */
// Top level of the connection table: configuration registers, port packing.
// Depends on ctt_pkg and ctt_engine.
//
// Usage: one word in on in_*, one or more result words out on out_*.
// The input word carries func in in_tuser; the others sit in in_tdata.
// The block handles one word at a time; in_tready is low while it works.
// A lookup reads the slots of the table memory one at a time, in order, so a
// data event, parser update or release scans slots until the handle matches,
// up to 32; a new handle scans all 32. A sweep visits every slot, with one
// result per timed-out slot, closed by a sweep-done word with out_tlast high;
// zero time gives only that word.
// Results leave through an output register; while the receiver holds
// out_tready low, the word holds and the scan waits at the next result.
// Reset clears all slots to free and loads the default timeouts; no memory
// clearing pass is needed. cfg_* writes are always accepted.
`default_nettype none
module connection_table_with_timeouts import ctt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // handle[15:0], recv_kind[17:16], byte_count[30:18], new_phase[32:31],
  // new_fill[45:33], now_ms[77:46], zero pad
  input  wire logic [79:0] in_tdata,
  // func[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // slot[4:0], handle_out[20:5], fill_out[33:21], zero pad
  output logic [39:0]      out_tdata,
  // status[3:0]
  output logic [3:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  cfg_t cfg_r;
  res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_to    <= 32'd10000;
      cfg_r.body_to      <= 32'd30000;
      cfg_r.keepalive_to <= 32'd5000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEADER:    cfg_r.header_to    <= cfg_data;
        REG_BODY:      cfg_r.body_to      <= cfg_data;
        REG_KEEPALIVE: cfg_r.keepalive_to <= cfg_data;
        default: ;
      endcase
    end
  end

  ctt_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_func(in_tuser),
    .in_handle(in_tdata[15:0]), .in_kind(in_tdata[17:16]),
    .in_cnt(in_tdata[30:18]), .in_phase(in_tdata[32:31]),
    .in_fill(in_tdata[45:33]), .in_now(in_tdata[77:46]),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {6'd0, res.fill, res.handle, res.slot};
  assign out_tuser = res.status;
  assign out_tlast = res.last;
endmodule
`default_nettype wire

/* rtl/ctt_ram.sv */
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module ctt_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/ctt_engine.sv */
// Sequencer of the connection table: scans the slot memory, applies events,
// owns the used bits and the result register. Depends on ctt_pkg, ctt_ram.
`default_nettype none
module ctt_engine import ctt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [HANDLE_W-1:0] in_handle,
  input  wire logic [1:0]  in_kind,
  input  wire logic [FILL_W-1:0] in_cnt,
  input  wire logic [1:0]  in_phase,
  input  wire logic [FILL_W-1:0] in_fill,
  input  wire logic [TIME_W-1:0] in_now,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             out_res
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_ACT  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [FILL_W:0]   BUF      = (FILL_W+1)'(BUFFER_BYTES);

  logic [2:0]          state_r, state_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic                found_r, found_nxt;
  logic                free_r, free_nxt;
  logic [SLOT_W-1:0]   sel_r, sel_nxt;
  entry_t              ent_r, ent_nxt;
  logic [1:0]          func_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [1:0]          kind_r;
  logic [FILL_W-1:0]   cnt_r;
  logic [1:0]          phase_r;
  logic [FILL_W-1:0]   fill_r;
  logic [TIME_W-1:0]   now_r;
  logic                ov_r, ov_nxt;
  res_t                res_r, res_nxt;

  entry_t              rd;
  logic [ENTRY_W-1:0]  rd_raw;
  logic                we;
  entry_t              wr;
  logic                can_emit;
  entry_t              e;
  logic [FILL_W:0]     sum;
  logic [TIME_W-1:0]   elapsed;
  logic                to;

  ctt_ram #(.W(ENTRY_W), .D(NUM_SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(sel_r), .wdata(wr),
    .raddr(idx_r), .rdata(rd_raw)
  );
  assign rd = entry_t'(rd_raw);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign can_emit  = !ov_r || out_ready;

  // Entry acted upon: the matched one, or a freshly allocated one.
  always_comb begin
    if (found_r) begin
      e = ent_r;
    end else begin
      e = '{handle: handle_r, phase: PH_IDLE, fill: '0, last_seen: now_r};
    end
    sum = {1'b0, e.fill} + {1'b0, cnt_r};
    elapsed = now_r - rd.last_seen;
    case (rd.phase)
      PH_HEADERS: to = elapsed >= cfg.header_to;
      PH_BODY:    to = elapsed >= cfg.body_to;
      PH_IDLE:    to = elapsed >= cfg.keepalive_to;
      default:    to = 1'b0;
    endcase
    to = to && used_r[idx_r] && (rd.last_seen != '0);
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    used_nxt  = used_r;
    found_nxt = found_r;
    free_nxt  = free_r;
    sel_nxt   = sel_r;
    ent_nxt   = ent_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r && !out_ready;
    we        = 1'b0;
    wr        = e;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = (in_func == FN_SWEEP && in_now == '0) ? S_DONE : S_RD;
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        if (func_r == FN_SWEEP) begin
          if (to && !can_emit) begin
            state_nxt = S_EV;
          end else begin
            if (to) begin
              used_nxt[idx_r] = 1'b0;
              ov_nxt  = 1'b1;
              res_nxt = '{status: ST_TIMEOUT, slot: 5'(idx_r), handle: rd.handle,
                          fill: '0, last: 1'b0};
            end
            idx_nxt   = idx_r + 1'b1;
            state_nxt = (idx_r == LAST_IDX) ? S_DONE : S_RD;
          end
        end else if (used_r[idx_r] && rd.handle == handle_r) begin
          found_nxt = 1'b1;
          ent_nxt   = rd;
          sel_nxt   = idx_r;
          state_nxt = S_ACT;
        end else begin
          if (!used_r[idx_r] && !free_r) begin
            free_nxt = 1'b1;
            sel_nxt  = idx_r;
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = (idx_r == LAST_IDX) ? S_ACT : S_RD;
        end
      end
      S_ACT: begin
        if (can_emit) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
          res_nxt   = '{status: ST_NODATA, slot: 5'(sel_r), handle: handle_r,
                        fill: e.fill, last: 1'b1};
          if (!found_r && (func_r != FN_DATA || !free_r)) begin
            res_nxt.slot   = '0;
            res_nxt.fill   = '0;
            res_nxt.status = (func_r == FN_DATA) ? ST_FULL : ST_NODATA;
          end else if (func_r == FN_DATA) begin
            used_nxt[sel_r] = 1'b1;
            we = 1'b1;
            if ({1'b0, e.fill} >= BUF) begin
              used_nxt[sel_r] = 1'b0;
              res_nxt.fill    = '0;
              res_nxt.status  = (e.phase == PH_HEADERS) ? ST_HDR_OVF :
                                (e.phase == PH_BODY) ? ST_BODY_OVF : ST_RELEASED;
            end else if (kind_r == RK_BYTES && cnt_r != '0) begin
              wr.fill      = (sum > BUF) ? BUF[FILL_W-1:0] : sum[FILL_W-1:0];
              wr.last_seen = now_r;
              if (e.phase == PH_IDLE) begin
                wr.phase = PH_HEADERS;
              end
              res_nxt.fill   = wr.fill;
              res_nxt.status = ST_DELIVERED;
            end else if (kind_r == RK_CLOSED) begin
              used_nxt[sel_r] = 1'b0;
              res_nxt.fill    = '0;
              res_nxt.status  = ST_CLOSED;
            end
          end else if (func_r == FN_PARSER) begin
            we       = 1'b1;
            wr.phase = phase_r;
            wr.fill  = ({1'b0, fill_r} > BUF) ? BUF[FILL_W-1:0] : fill_r;
            res_nxt.fill   = wr.fill;
            res_nxt.status = ST_PHASE;
          end else begin
            used_nxt[sel_r] = 1'b0;
            res_nxt.fill    = '0;
            res_nxt.status  = ST_RELEASED;
          end
        end
      end
      S_DONE: begin
        if (can_emit) begin
          ov_nxt    = 1'b1;
          res_nxt   = '{status: ST_SWEEP, slot: '0, handle: '0, fill: '0, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    free_r  <= free_nxt;
    sel_r   <= sel_nxt;
    ent_r   <= ent_nxt;
    res_r   <= res_nxt;
    if (state_r == S_IDLE && in_valid) begin
      func_r   <= in_func;
      handle_r <= in_handle;
      kind_r   <= in_kind;
      cnt_r    <= in_cnt;
      phase_r  <= in_phase;
      fill_r   <= in_fill;
      now_r    <= in_now;
    end
  end
endmodule
`default_nettype wire

/* rtl/ctt_checker.sv */
// Port-level checker for the connection table, bound to the top level.
// Depends on ctt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ctt_checker import ctt_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [3:0]  out_tuser,
  input wire logic        out_tlast
);
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_IMP(a_sweep_last, clk, rst_n, out_tvalid && out_tuser == ST_SWEEP, out_tlast)
  `ASSERT_IMP(a_timeout_not_last, clk, rst_n, out_tvalid && out_tuser == ST_TIMEOUT, !out_tlast)
endmodule

bind connection_table_with_timeouts ctt_checker u_ctt_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
`default_nettype wire

/* test/connection_table_with_timeouts_tb.sv */
// Testbench of the connection table: directed and random events, sweeps and
// register writes, checked against a behavioral predictor. Needs ctt_pkg, DUT.
`default_nettype none
module connection_table_with_timeouts_tb;
  import ctt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class conn_scoreboard;
    logic [31:0] tmo_header, tmo_body, tmo_keepalive;
    bit          used [NUM_SLOTS];
    logic [15:0] hnd [NUM_SLOTS];
    logic [1:0]  phase [NUM_SLOTS];
    int          fill [NUM_SLOTS];
    logic [31:0] seen [NUM_SLOTS];
    res_t        pending[$];
    int          errors;

    function void reset_state();
      tmo_header = 10000; tmo_body = 30000; tmo_keepalive = 5000;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        used[i] = 0; hnd[i] = 0; phase[i] = PH_IDLE; fill[i] = 0; seen[i] = 0;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_HEADER:    tmo_header = val;
        REG_BODY:      tmo_body = val;
        REG_KEEPALIVE: tmo_keepalive = val;
        default: ;
      endcase
    endfunction

    function void push(logic [3:0] st, int s, logic [15:0] h, int f, bit lst);
      res_t r;
      r.status = st; r.slot = s[4:0]; r.handle = h; r.fill = f[12:0]; r.last = lst;
      pending.push_back(r);
    endfunction

    function int lookup(logic [15:0] h);
      for (int i = 0; i < NUM_SLOTS; i++)
        if (used[i] && hnd[i] == h) return i;
      return -1;
    endfunction

    // Works out the results that one accepted input word causes.
    function void note_input(logic [1:0] fn, logic [15:0] h, logic [1:0] kind,
                             int cnt, logic [1:0] nph, int nfill, logic [31:0] now);
      int i;
      logic [3:0] st;
      logic [31:0] el;
      bit hit;
      if (fn == FN_DATA) begin
        i = lookup(h);
        if (i < 0) begin
          i = 0;
          while (i < NUM_SLOTS && used[i]) i++;
          if (i >= NUM_SLOTS) begin
            push(ST_FULL, 0, h, 0, 1);
            return;
          end
          used[i] = 1; hnd[i] = h; fill[i] = 0; phase[i] = PH_IDLE; seen[i] = now;
        end
        if (fill[i] >= BUFFER_BYTES) begin
          st = ST_RELEASED;
          if (phase[i] == PH_HEADERS) st = ST_HDR_OVF;
          else if (phase[i] == PH_BODY) st = ST_BODY_OVF;
          used[i] = 0; fill[i] = 0; phase[i] = PH_IDLE;
          push(st, i, h, 0, 1);
        end else if (kind == RK_BYTES && cnt != 0) begin
          if (cnt > BUFFER_BYTES - fill[i]) cnt = BUFFER_BYTES - fill[i];
          fill[i] += cnt; seen[i] = now;
          if (phase[i] == PH_IDLE) phase[i] = PH_HEADERS;
          push(ST_DELIVERED, i, h, fill[i], 1);
        end else if (kind == RK_CLOSED) begin
          used[i] = 0; fill[i] = 0; phase[i] = PH_IDLE;
          push(ST_CLOSED, i, h, 0, 1);
        end else begin
          push(ST_NODATA, i, h, fill[i], 1);
        end
      end else if (fn == FN_PARSER || fn == FN_RELEASE) begin
        i = lookup(h);
        if (i < 0) push(ST_NODATA, 0, h, 0, 1);
        else if (fn == FN_PARSER) begin
          phase[i] = nph;
          fill[i] = (nfill > BUFFER_BYTES) ? BUFFER_BYTES : nfill;
          push(ST_PHASE, i, h, fill[i], 1);
        end else begin
          used[i] = 0; fill[i] = 0; phase[i] = PH_IDLE;
          push(ST_RELEASED, i, h, 0, 1);
        end
      end else begin
        if (now != 0) begin
          for (int j = 0; j < NUM_SLOTS; j++) begin
            if (!used[j] || seen[j] == 0) continue;
            el = now - seen[j];
            hit = 0;
            if (phase[j] == PH_HEADERS) hit = el >= tmo_header;
            else if (phase[j] == PH_BODY) hit = el >= tmo_body;
            else if (phase[j] == PH_IDLE) hit = el >= tmo_keepalive;
            if (hit) begin
              used[j] = 0; fill[j] = 0; phase[j] = PH_IDLE;
              push(ST_TIMEOUT, j, hnd[j], 0, 0);
            end
          end
        end
        push(ST_SWEEP, 0, 16'd0, 0, 1);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_valid = 0;
  logic [79:0] in_tdata = '0;
  logic [1:0] in_tuser = '0, cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_tready, out_tvalid, out_tlast, cfg_ready;
  logic [39:0] out_tdata;
  logic [3:0] out_tuser;

  conn_scoreboard sb = new();
  int hold_off = 0;   // forced receiver stall, in cycles
  int idle_cycles = 0;
  logic [31:0] clock_ms = 1;
  logic [15:0] handle_pool [8];

  always #5 clk = ~clk;

  connection_table_with_timeouts u_dut (.*);

  // The valid line is dropped only when a gap follows, so that it never sees
  // two updates in one time step; drain() drops it at the end of a burst.
  task automatic send_word(logic [1:0] fn, logic [15:0] h, logic [1:0] kind,
                           logic [12:0] cnt, logic [1:0] nph, logic [12:0] nfill,
                           logic [31:0] now, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= fn;
    in_tdata  <= {2'b00, now, nfill, nph, cnt, kind, h};
    do @(posedge clk); while (!in_tready);
    sb.note_input(fn, h, kind, cnt, nph, nfill, now);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_word();
    logic [1:0] fn;
    logic [15:0] h;
    logic [12:0] cnt, nfill;
    int r;
    r = $urandom_range(0, 99);
    fn = (r < 55) ? FN_DATA : (r < 75) ? FN_PARSER : (r < 88) ? FN_RELEASE : FN_SWEEP;
    h = ($urandom_range(0, 4) == 0) ? 16'($urandom) : handle_pool[$urandom_range(0, 7)];
    cnt = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4096));
    nfill = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4096));
    clock_ms = clock_ms + $urandom_range(0, 3000);
    send_word(fn, h, 2'($urandom_range(0, 3)), cnt, 2'($urandom),
              nfill, ($urandom_range(0, 30) == 0) ? 32'd0 : clock_ms);
  endtask

  // Result side: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser; got.slot = out_tdata[4:0];
      got.handle = out_tdata[20:5]; got.fill = out_tdata[33:21]; got.last = out_tlast;
      sb.check_result(got);
    end
  end

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_tready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      out_tready <= 0;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("connection_table_with_timeouts_tb: FAIL");
      $finish;
    end
  end

  initial begin
    sb.reset_state();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 8; i++) handle_pool[i] = 16'($urandom);
    handle_pool[0] = 16'h0000;
    handle_pool[1] = 16'hFFFF;

    // Directed: extremes, overflows per phase, closes, unknown handles.
    send_word(FN_DATA, 16'h0000, RK_BYTES, 13'd4096, 2'd0, 13'd0, 32'd100);
    send_word(FN_DATA, 16'h0000, RK_BYTES, 13'd5, 2'd0, 13'd0, 32'd110);
    send_word(FN_DATA, 16'h0000, RK_BYTES, 13'd1, 2'd0, 13'd0, 32'd120);
    send_word(FN_DATA, 16'hFFFF, RK_BYTES, 13'd0, 2'd0, 13'd0, 32'hFFFFFFFF);
    send_word(FN_DATA, 16'hFFFF, 2'd3, 13'h1FFF, 2'd3, 13'h1FFF, 32'hFFFFFFFF);
    send_word(FN_PARSER, 16'hFFFF, 2'd0, 13'd0, PH_BODY, 13'h1FFF, 32'd0);
    send_word(FN_DATA, 16'hFFFF, RK_BYTES, 13'd1, 2'd0, 13'd0, 32'd5);
    send_word(FN_DATA, 16'h1234, 2'd1, 13'd0, 2'd0, 13'd0, 32'd0);
    send_word(FN_PARSER, 16'h1234, 2'd0, 13'd0, 2'd3, 13'd4096, 32'd0);
    send_word(FN_DATA, 16'h1234, RK_BYTES, 13'd9, 2'd0, 13'd0, 32'd7);
    send_word(FN_DATA, 16'h4321, RK_CLOSED, 13'd9, 2'd0, 13'd0, 32'd7);
    send_word(FN_PARSER, 16'hBEEF, 2'd0, 13'd0, PH_HEADERS, 13'd10, 32'd0);
    send_word(FN_RELEASE, 16'hBEEF, 2'd0, 13'd0, 2'd0, 13'd0, 32'd0);
    send_word(FN_DATA, 16'h0042, RK_BYTES, 13'd3, 2'd0, 13'd0, 32'd1000);
    send_word(FN_PARSER, 16'h0042, 2'd0, 13'd0, PH_IDLE, 13'd0, 32'd0);
    send_word(FN_SWEEP, 16'h0000, 2'd0, 13'd0, 2'd0, 13'd0, 32'd0);
    send_word(FN_SWEEP, 16'h0000, 2'd0, 13'd0, 2'd0, 13'd0, 32'd2000000);
    send_word(FN_RELEASE, 16'h1234, 2'd0, 13'd0, 2'd0, 13'd0, 32'd0);
    // Fill the table, hit table full, then sweep at a wrapped time.
    for (int i = 0; i < 33; i++)
      send_word(FN_DATA, 16'h7000 + 16'(i), RK_BYTES, 13'd1, 2'd0, 13'd0,
                32'hFFFFFF00, 0);
    drain();
    write_reg(REG_HEADER, 32'd0);
    write_reg(REG_BODY, 32'hFFFFFFFF);
    write_reg(REG_KEEPALIVE, 32'd0);
    send_word(FN_SWEEP, 16'h0000, 2'd0, 13'd0, 2'd0, 13'd0, 32'd5);

    // Long receiver hold-off while the sender keeps offering words.
    hold_off = 400;
    for (int i = 0; i < 10; i++) random_word();
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin write_reg(REG_HEADER, 32'd10000); write_reg(REG_BODY, 32'd30000);
                 write_reg(REG_KEEPALIVE, 32'd5000); end
        1: begin write_reg(REG_HEADER, 32'd3000); write_reg(REG_BODY, 32'd8000);
                 write_reg(REG_KEEPALIVE, 32'd1500); end
        2: begin write_reg(REG_HEADER, 32'hFFFFFFFF); write_reg(REG_BODY, 32'd0);
                 write_reg(REG_KEEPALIVE, 32'hFFFFFFFF); end
        default: begin write_reg(REG_HEADER, $urandom); write_reg(REG_BODY, $urandom);
                       write_reg(REG_KEEPALIVE, $urandom_range(0, 20000)); end
      endcase
      for (int i = 0; i < 95; i++) random_word();
      drain();   // the sender waits until every expected result has come
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("connection_table_with_timeouts_tb: PASS");
    else
      $display("connection_table_with_timeouts_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/ctt_pkg.sv
rtl/ctt_ram.sv
rtl/ctt_engine.sv
rtl/connection_table_with_timeouts.sv
rtl/ctt_checker.sv
test/connection_table_with_timeouts_tb.sv
